// File: rtl/wstd_pkg.sv
// shared types and constants for the work-stealing task deque block
`default_nettype none

package wstd_pkg;

    // input field widths
    localparam int KIND_W     = 2;
    localparam int WORKER_W   = 2;
    localparam int TASK_REQ_W = 16;

    // output field widths
    localparam int STATUS_W   = 3;
    localparam int TASK_OUT_W = 16;
    localparam int SOURCE_W   = 2;
    localparam int STEAL_W    = 16;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    // widest sum used in the victim rotation (worker id plus offset)
    localparam int ROT_W      = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH  = 2'd0,
        KIND_FETCH = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OWN     = 3'd0,
        ST_STOLEN  = 3'd1,
        ST_NONE    = 3'd2,
        ST_PUSHED  = 3'd3,
        ST_REFUSED = 3'd4,
        ST_CLEARED = 3'd5
    } status_t;

endpackage

`default_nettype wire

// File: rtl/wstd_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module wstd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/wstd_victim.sv
// rotating find-first over the non-empty deque flags, starting after the requester
`default_nettype none

module wstd_victim #(
    parameter int WORKERS = 4
) (
    input  wire logic [WORKERS-1:0]         busy,
    input  wire logic [$clog2(WORKERS)-1:0] requester,
    output logic                            found,
    output logic      [$clog2(WORKERS)-1:0] victim
);

    localparam int WIW = $clog2(WORKERS);
    localparam int RW  = wstd_pkg::ROT_W;

    logic [RW-1:0] idx [WORKERS];
    logic          cand [WORKERS];

    // candidate id for each offset, wrapped once modulo the worker count
    always_comb begin
        logic [RW-1:0] sum;
        for (int i = 0; i < WORKERS; i++) begin
            sum = RW'(requester) + RW'(i);
            if (sum >= RW'(WORKERS)) begin
                sum = sum - RW'(WORKERS);
            end
            if (sum >= RW'(WORKERS)) begin
                // requester out of range, answer is not used
                sum = '0;
            end
            idx[i]  = sum;
            cand[i] = (i != 0) && busy[sum[WIW-1:0]];
        end
    end

    // lowest offset wins
    always_comb begin
        found  = 1'b0;
        victim = '0;
        for (int i = WORKERS - 1; i >= 1; i--) begin
            if (cand[i]) begin
                found  = 1'b1;
                victim = idx[i][WIW-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/work_stealing_task_deques_top.sv
// top level of the work-stealing task deque scheduler
`default_nettype none

// One task deque per worker, each a ring of DEQUE_DEPTH slots in a shared task
// ram. A request transaction (kind in s_tuser) pushes a task at a worker's tail,
// fetches from a worker's head, or clears every deque and the steal count. A
// fetch on an empty own deque, with steal_enable set, takes the tail task of the
// first non-empty deque after the requester in rotating order and counts a
// steal (saturating). Every request yields exactly one result transaction.
// Throughput is one transaction per cycle while the result side is ready: the
// whole decision (empty/full flags, victim search, index update) is done in
// the accept cycle, and the task ram read issued there returns in the next
// cycle, while the transaction sits in stage 1; the output register then holds
// the result. The task ram has no reset and no clearing pass; only written
// slots are ever read. steal_enable is written through cfg_we/cfg_wdata and takes effect for the next request.

module work_stealing_task_deques_top #(
    parameter int WORKERS     = 4,
    parameter int DEQUE_DEPTH = 128,
    parameter int TASK_BITS   = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration: steal_enable
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_wdata,
    // request channel
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [1:0] worker, [17:2] task_req, [23:18] zero
    input  wire logic [wstd_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] kind
    input  wire logic [wstd_pkg::KIND_W-1:0]      s_tuser,
    // result channel
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [15:0] task_out, [17:16] source_worker, [33:18] steal_total, [39:34] zero
    output logic      [wstd_pkg::M_TDATA_W-1:0]   m_tdata,
    // [2:0] status
    output logic      [wstd_pkg::STATUS_W-1:0]    m_tuser
);

    localparam int WIW    = $clog2(WORKERS);
    localparam int SW     = $clog2(DEQUE_DEPTH);
    localparam int ADDR_W = $clog2(WORKERS * DEQUE_DEPTH);
    localparam int WW     = wstd_pkg::WORKER_W;
    localparam int TRW    = wstd_pkg::TASK_REQ_W;
    localparam int TOW    = wstd_pkg::TASK_OUT_W;
    localparam int SRW    = wstd_pkg::SOURCE_W;
    localparam int STW    = wstd_pkg::STEAL_W;
    localparam int RW     = wstd_pkg::ROT_W;

    // ---------------------------------------------------------------
    // state: per-worker ring indices (slot plus wrap bit), steal count
    // ---------------------------------------------------------------
    logic [SW-1:0]  head_slot_reg  [WORKERS];
    logic           head_wrap_reg  [WORKERS];
    logic [SW-1:0]  tail_slot_reg  [WORKERS];
    logic           tail_wrap_reg  [WORKERS];
    logic [SW-1:0]  head_slot_next [WORKERS];
    logic           head_wrap_next [WORKERS];
    logic [SW-1:0]  tail_slot_next [WORKERS];
    logic           tail_wrap_next [WORKERS];
    logic [STW-1:0] steal_cnt_reg;
    logic [STW-1:0] steal_cnt_next;
    logic           steal_en_reg;

    // ---------------------------------------------------------------
    // request decode
    // ---------------------------------------------------------------
    wstd_pkg::kind_t kind_in;
    logic [WW-1:0]   worker_in;
    logic [TRW-1:0]  task_in;
    logic            worker_ok;
    logic [WIW-1:0]  widx;
    logic            s_acc;

    assign kind_in   = wstd_pkg::kind_t'(s_tuser);
    assign worker_in = s_tdata[WW-1:0];
    assign task_in   = s_tdata[WW+TRW-1:WW];
    assign worker_ok = RW'(worker_in) < RW'(WORKERS);
    assign widx      = WIW'(worker_in);
    assign s_acc     = s_tvalid && s_tready;

    // per-lane occupancy flags
    logic [WORKERS-1:0] busy;
    logic [WORKERS-1:0] full;

    always_comb begin
        for (int i = 0; i < WORKERS; i++) begin
            busy[i] = (head_slot_reg[i] != tail_slot_reg[i]) ||
                      (head_wrap_reg[i] != tail_wrap_reg[i]);
            full[i] = (head_slot_reg[i] == tail_slot_reg[i]) &&
                      (head_wrap_reg[i] != tail_wrap_reg[i]);
        end
    end

    // victim search for steals
    logic           vic_found;
    logic [WIW-1:0] vic_idx;

    wstd_victim #(
        .WORKERS (WORKERS)
    ) u_victim (
        .busy      (busy),
        .requester (widx),
        .found     (vic_found),
        .victim    (vic_idx)
    );

    // ---------------------------------------------------------------
    // single-pass decision
    // ---------------------------------------------------------------
    wstd_pkg::status_t status_d;
    logic [SRW-1:0]    src_d;
    logic              use_d;
    logic              ram_we_d;
    logic              ram_re_d;
    logic [ADDR_W-1:0] waddr_d;
    logic [ADDR_W-1:0] raddr_d;

    always_comb begin
        logic [SW-1:0] slot;
        logic          wrap;
        status_d       = wstd_pkg::ST_NONE;
        src_d          = '0;
        use_d          = 1'b0;
        ram_we_d       = 1'b0;
        ram_re_d       = 1'b0;
        waddr_d        = '0;
        raddr_d        = '0;
        slot           = '0;
        wrap           = 1'b0;
        head_slot_next = head_slot_reg;
        head_wrap_next = head_wrap_reg;
        tail_slot_next = tail_slot_reg;
        tail_wrap_next = tail_wrap_reg;
        steal_cnt_next = steal_cnt_reg;

        case (kind_in)
            wstd_pkg::KIND_PUSH: begin
                src_d = SRW'(worker_in);
                if (!worker_ok || full[widx]) begin
                    status_d = wstd_pkg::ST_REFUSED;
                end else begin
                    status_d = wstd_pkg::ST_PUSHED;
                    slot     = tail_slot_reg[widx];
                    ram_we_d = 1'b1;
                    waddr_d  = ADDR_W'(widx) * ADDR_W'(DEQUE_DEPTH) + ADDR_W'(slot);
                    if (slot == SW'(DEQUE_DEPTH - 1)) begin
                        tail_slot_next[widx] = '0;
                        tail_wrap_next[widx] = !tail_wrap_reg[widx];
                    end else begin
                        tail_slot_next[widx] = slot + SW'(1);
                    end
                end
            end
            wstd_pkg::KIND_FETCH: begin
                if (worker_ok) begin
                    if (busy[widx]) begin
                        // own head task
                        status_d = wstd_pkg::ST_OWN;
                        src_d    = SRW'(worker_in);
                        use_d    = 1'b1;
                        slot     = head_slot_reg[widx];
                        ram_re_d = 1'b1;
                        raddr_d  = ADDR_W'(widx) * ADDR_W'(DEQUE_DEPTH) + ADDR_W'(slot);
                        if (slot == SW'(DEQUE_DEPTH - 1)) begin
                            head_slot_next[widx] = '0;
                            head_wrap_next[widx] = !head_wrap_reg[widx];
                        end else begin
                            head_slot_next[widx] = slot + SW'(1);
                        end
                    end else if (steal_en_reg && vic_found) begin
                        // victim's tail task, tail steps back first
                        status_d = wstd_pkg::ST_STOLEN;
                        src_d    = SRW'(vic_idx);
                        use_d    = 1'b1;
                        wrap     = tail_wrap_reg[vic_idx];
                        if (tail_slot_reg[vic_idx] == '0) begin
                            slot = SW'(DEQUE_DEPTH - 1);
                            wrap = !wrap;
                        end else begin
                            slot = tail_slot_reg[vic_idx] - SW'(1);
                        end
                        tail_slot_next[vic_idx] = slot;
                        tail_wrap_next[vic_idx] = wrap;
                        ram_re_d = 1'b1;
                        raddr_d  = ADDR_W'(vic_idx) * ADDR_W'(DEQUE_DEPTH) + ADDR_W'(slot);
                        if (steal_cnt_reg != '1) begin
                            steal_cnt_next = steal_cnt_reg + STW'(1);
                        end
                    end
                end
            end
            wstd_pkg::KIND_CLEAR: begin
                status_d = wstd_pkg::ST_CLEARED;
                for (int i = 0; i < WORKERS; i++) begin
                    head_slot_next[i] = '0;
                    head_wrap_next[i] = 1'b0;
                    tail_slot_next[i] = '0;
                    tail_wrap_next[i] = 1'b0;
                end
                steal_cnt_next = '0;
            end
            default: begin
                status_d = wstd_pkg::ST_NONE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // state registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WORKERS; i++) begin
                head_slot_reg[i] <= '0;
                head_wrap_reg[i] <= 1'b0;
                tail_slot_reg[i] <= '0;
                tail_wrap_reg[i] <= 1'b0;
            end
            steal_cnt_reg <= '0;
        end else if (s_acc) begin
            head_slot_reg <= head_slot_next;
            head_wrap_reg <= head_wrap_next;
            tail_slot_reg <= tail_slot_next;
            tail_wrap_reg <= tail_wrap_next;
            steal_cnt_reg <= steal_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steal_en_reg <= 1'b0;
        end else if (cfg_we) begin
            steal_en_reg <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------------
    // task store
    // ---------------------------------------------------------------
    logic [TASK_BITS-1:0] ram_rdata;

    wstd_ram #(
        .WIDTH (TASK_BITS),
        .DEPTH (WORKERS * DEQUE_DEPTH)
    ) u_task_ram (
        .aclk  (aclk),
        .we    (s_acc && ram_we_d),
        .waddr (waddr_d),
        .wdata (TASK_BITS'(task_in)),
        .re    (s_acc && ram_re_d),
        .raddr (raddr_d),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // stage 1 (ram read in flight) and output register
    // ---------------------------------------------------------------
    logic              st1_valid_reg;
    wstd_pkg::status_t st1_status_reg;
    logic [SRW-1:0]    st1_src_reg;
    logic [STW-1:0]    st1_steal_reg;
    logic              st1_use_reg;

    logic              m_valid_reg;
    wstd_pkg::status_t m_status_reg;
    logic [TOW-1:0]    m_task_reg;
    logic [SRW-1:0]    m_src_reg;
    logic [STW-1:0]    m_steal_reg;

    logic              out_adv;

    // output slot free or draining this cycle
    assign out_adv  = !m_valid_reg || m_tready;
    // stage 1 holds ram data, so while full it only takes a new transaction when it moves on
    assign s_tready = !st1_valid_reg || out_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            st1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            st1_status_reg <= status_d;
            st1_src_reg    <= src_d;
            st1_steal_reg  <= steal_cnt_next;
            st1_use_reg    <= use_d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && st1_valid_reg) begin
            m_status_reg <= st1_status_reg;
            m_task_reg   <= st1_use_reg ? TOW'(ram_rdata) : '0;
            m_src_reg    <= st1_src_reg;
            m_steal_reg  <= st1_steal_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {
        (wstd_pkg::M_TDATA_W - TOW - SRW - STW)'(0),
        m_steal_reg, m_src_reg, m_task_reg
    };

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // a clear always reports a zero steal count
    a_clear_zero_steals: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == wstd_pkg::ST_CLEARED) |-> (m_tdata[33:18] == '0))
        else $error("cleared result with non-zero steal total");

    // task field is zero unless a task was handed out
    a_task_only_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != wstd_pkg::ST_OWN) && (m_tuser != wstd_pkg::ST_STOLEN)
        |-> (m_tdata[15:0] == '0))
        else $error("task data on a result without a task");

    // steal count only drops through a clear
    a_steal_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_acc && (kind_in == wstd_pkg::KIND_CLEAR)) |=> (steal_cnt_reg >= $past(steal_cnt_reg)))
        else $error("steal count decreased without a clear");

    // a steal never happens with stealing disabled
    a_no_steal_when_off: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && !steal_en_reg |-> (status_d != wstd_pkg::ST_STOLEN))
        else $error("steal while stealing is disabled");

    // empty stage 1 never blocks requests
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !st1_valid_reg |-> s_tready)
        else $error("request side stalled with stage 1 empty");

endmodule

`default_nettype wire
